[sv/swt_pkg.sv]
`timescale 1ns / 1ps

package swt_pkg;

   localparam int unsigned SLOTS_DEFAULT = 1024;

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned PAGE_W   = 52;
   localparam int unsigned APP_W    = 8;
   localparam int unsigned SLOT_W   = 10;
   localparam int unsigned COUNT_W  = 32;
   localparam int unsigned LIMIT_W  = 11;

   // 1 MB of swap is 1024/4 slots; reset limit is 4 MB worth
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4 * (1024 / 4));

   localparam logic [KIND_W-1:0] KIND_LOOKUP   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SWAP_IN  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SWAP_OUT = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [PAGE_W-1:0] page_number;
      logic [APP_W-1:0]  app_id;
   } req_type;

   typedef struct packed {
      logic               found;
      logic               accepted;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] swap_in_count;
      logic [COUNT_W-1:0] swap_out_count;
      logic [COUNT_W-1:0] failed_count;
   } rsp_type;

   typedef struct packed {
      logic              used;
      logic [APP_W-1:0]  app;
      logic [PAGE_W-1:0] page;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic start;
      logic scan;
      logic free_old;
      logic write_new;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic addr_last;
      logic found;
      logic free_ok;
      logic is_in;
      logic is_out;
      logic rsp_room;
   } status_type;

endpackage

[sv/swt_dpath.sv]
`timescale 1ns / 1ps

module swt_dpath #(
   parameter int unsigned SLOTS = swt_pkg::SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  swt_pkg::cmd_type                 cmd,
   output swt_pkg::status_type              status,
   input  swt_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output swt_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [swt_pkg::LIMIT_W-1:0]      csr_wr_data
);

   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned CMP_W =
      (IDX_W + 1 > swt_pkg::LIMIT_W) ? IDX_W + 1 : swt_pkg::LIMIT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   swt_pkg::entry_type slot_mem [SLOTS];

   logic [swt_pkg::LIMIT_W-1:0] limit_ff;
   logic [IDX_W-1:0]            addr_ff;
   swt_pkg::req_type            req_ff;
   logic                        rd_vld_ff;
   logic [IDX_W-1:0]            rd_idx_ff;
   swt_pkg::entry_type          rd_q_ff;
   logic                        found_ff;
   logic [IDX_W-1:0]            old_idx_ff;
   logic                        free_ok_ff;
   logic [IDX_W-1:0]            free_idx_ff;
   logic [swt_pkg::COUNT_W-1:0] ins_ff;
   logic [swt_pkg::COUNT_W-1:0] outs_ff;
   logic [swt_pkg::COUNT_W-1:0] fails_ff;
   logic                        rsp_valid_ff;
   swt_pkg::rsp_type            rsp_ff;

   logic [swt_pkg::COUNT_W-1:0] ins_in;
   logic [swt_pkg::COUNT_W-1:0] outs_in;
   logic [swt_pkg::COUNT_W-1:0] fails_in;
   swt_pkg::rsp_type            rsp_in;

   logic                        wr_en;
   logic [IDX_W-1:0]            wr_idx;
   swt_pkg::entry_type          wr_entry;
   logic                        hit;
   logic                        hole;
   logic                        is_in;
   logic                        is_out;
   logic [IDX_W-1:0]            sel_idx;
   logic                        sel_valid;
   logic [IDX_W+swt_pkg::SLOT_W-1:0] slot_wide;

   assign is_in  = (req_ff.kind == swt_pkg::KIND_SWAP_IN);
   assign is_out = (req_ff.kind == swt_pkg::KIND_SWAP_OUT);

   assign hit  = rd_vld_ff && rd_q_ff.used
                 && (rd_q_ff.page == req_ff.page_number)
                 && (rd_q_ff.app == req_ff.app_id);
   assign hole = rd_vld_ff && !rd_q_ff.used
                 && (CMP_W'(rd_idx_ff) < CMP_W'(limit_ff));

   always_comb begin
      wr_en    = cmd.clear || cmd.free_old || cmd.write_new;
      wr_idx   = addr_ff;
      wr_entry = '0;
      if (cmd.free_old) begin
         wr_idx = old_idx_ff;
      end else if (cmd.write_new) begin
         wr_idx        = free_idx_ff;
         wr_entry.used = 1'b1;
         wr_entry.app  = req_ff.app_id;
         wr_entry.page = req_ff.page_number;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_idx] <= wr_entry;
      end
      if (cmd.scan) begin
         rd_q_ff <= slot_mem[addr_ff];
      end
   end

   always_comb begin
      ins_in   = is_in ? ins_ff + 1'b1 : ins_ff;
      outs_in  = (is_out && free_ok_ff) ? outs_ff + 1'b1 : outs_ff;
      fails_in = (is_out && !free_ok_ff) ? fails_ff + 1'b1 : fails_ff;
      sel_idx   = is_out ? free_idx_ff : old_idx_ff;
      sel_valid = is_out ? free_ok_ff : found_ff;
      slot_wide = {{swt_pkg::SLOT_W{1'b0}}, sel_idx};
      rsp_in.found          = found_ff;
      rsp_in.accepted       = is_out && free_ok_ff;
      rsp_in.slot           = sel_valid ? slot_wide[swt_pkg::SLOT_W-1:0] : '0;
      rsp_in.swap_in_count  = ins_in;
      rsp_in.swap_out_count = outs_in;
      rsp_in.failed_count   = fails_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= swt_pkg::LIMIT_RESET;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         free_ok_ff   <= 1'b0;
         ins_ff       <= '0;
         outs_ff      <= '0;
         fails_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         rd_vld_ff <= cmd.scan;
         if (cmd.start) begin
            addr_ff    <= '0;
            found_ff   <= 1'b0;
            free_ok_ff <= 1'b0;
         end else begin
            if (cmd.clear || cmd.scan) begin
               addr_ff <= addr_ff + 1'b1;
            end
            if (hit) begin
               found_ff <= 1'b1;
            end
            if (hole) begin
               free_ok_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            ins_ff       <= ins_in;
            outs_ff      <= outs_in;
            fails_ff     <= fails_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff <= req_data;
      end
      if (cmd.scan) begin
         rd_idx_ff <= addr_ff;
      end
      // lowest index wins
      if (hit && !found_ff) begin
         old_idx_ff <= rd_idx_ff;
      end
      if (hole && !free_ok_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.addr_last = (addr_ff == LAST_IDX);
   assign status.found     = found_ff;
   assign status.free_ok   = free_ok_ff;
   assign status.is_in     = is_in;
   assign status.is_out    = is_out;
   assign status.rsp_room  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/swt_ctrl.sv]
`timescale 1ns / 1ps

module swt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  swt_pkg::status_type status,
   output swt_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_FREE,
      ST_WRITE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_stall_ff;
   logic      place_new;

   assign place_new = status.is_out && status.free_ok;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.addr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && !req_stall_ff) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.addr_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.found && (status.is_in || place_new)) begin
               state_in = ST_FREE;
            end else if (place_new) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FREE: begin
            cmd.free_old = 1'b1;
            state_in     = place_new ? ST_WRITE : ST_FINISH;
         end
         ST_WRITE: begin
            cmd.write_new = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_room) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_stall_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

endmodule

[sv/swap_slot_table_unit.sv]
`timescale 1ns / 1ps

// Channel   Valid      Stall      Payload       Direction
// request   req_valid  req_stall  req_data      in
// response  rsp_valid  rsp_stall  rsp_data      out
// csr       csr_wr_en  -          csr_wr_data   in
//
// One request at a time, each scanning the slot memory through its single read
// port, one entry a cycle.
// After reset a clearing pass writes every slot free with req_stall high; csr
// writes are taken during it.
// A finished response waits in an output register while the next request is
// accepted and scanned.

module swap_slot_table_unit #(
   parameter int unsigned SLOTS = swt_pkg::SLOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  swt_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output swt_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [swt_pkg::LIMIT_W-1:0] csr_wr_data
);

   swt_pkg::cmd_type    cmd;
   swt_pkg::status_type status;

   swt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   swt_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a request is in flight");

   a_write_needs_free: assert property (@(posedge clock) disable iff (reset)
      cmd.write_new |-> (status.free_ok && status.is_out))
      else $error("slot written without a free slot");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || !rsp_stall))
      else $error("pending response overwritten");

   a_no_scan_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> req_stall)
      else $error("scan while request port open");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int SLOTS       = swt_pkg::SLOTS_DEFAULT;
   localparam int KEYS        = 16;
   localparam int SETTLE      = SLOTS + 76;
   localparam int CYCLE_LIMIT = 3_000_000;

   localparam logic [swt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   swt_pkg::req_type             req_data = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   swt_pkg::rsp_type             rsp_data;
   logic                         csr_wr_en = 1'b0;
   logic [swt_pkg::LIMIT_W-1:0]  csr_wr_data = '0;

   // slot table as the block should hold it
   bit                           held [SLOTS];
   logic [swt_pkg::PAGE_W-1:0]   held_page [SLOTS];
   logic [swt_pkg::APP_W-1:0]    held_app [SLOTS];
   logic [swt_pkg::COUNT_W-1:0]  ins_tally = '0;
   logic [swt_pkg::COUNT_W-1:0]  outs_tally = '0;
   logic [swt_pkg::COUNT_W-1:0]  swap_fails = '0;
   logic [swt_pkg::LIMIT_W-1:0]  limit_setting = swt_pkg::LIMIT_RESET;

   logic [swt_pkg::PAGE_W-1:0]   key_page [KEYS];
   logic [swt_pkg::APP_W-1:0]    key_app [KEYS];

   swt_pkg::rsp_type             pending_rsp [$];
   int                           sender_idle_pct = 0;
   int                           receiver_stall_pct = 0;
   int                           errors = 0;
   int                           sent = 0;
   int                           limit_writes = 0;
   int                           cycles = 0;

   swap_slot_table_unit #(
      .SLOTS(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles,
                  pending_rsp.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   function automatic swt_pkg::rsp_type apply_request(swt_pkg::req_type r);
      swt_pkg::rsp_type res;
      int      i;
      int      hit_at;
      int      free_at;
      int      bound;
      res = '0;
      hit_at = -1;
      free_at = -1;
      for (i = 0; i < SLOTS; i++) begin
         if (hit_at < 0 && held[i] && held_page[i] == r.page_number &&
             held_app[i] == r.app_id) begin
            hit_at = i;
         end
      end
      bound = (int'(limit_setting) > SLOTS) ? SLOTS : int'(limit_setting);
      for (i = 0; i < bound; i++) begin
         if (free_at < 0 && !held[i]) begin
            free_at = i;
         end
      end
      res.found = (hit_at >= 0);
      if (r.kind == swt_pkg::KIND_SWAP_IN) begin
         if (hit_at >= 0) begin
            held[hit_at] = 1'b0;
            res.slot = swt_pkg::SLOT_W'(hit_at);
         end
         ins_tally++;
      end else if (r.kind == swt_pkg::KIND_SWAP_OUT) begin
         if (free_at >= 0) begin
            // old slot stays held during the search, released only on success
            if (hit_at >= 0) begin
               held[hit_at] = 1'b0;
            end
            held[free_at] = 1'b1;
            held_page[free_at] = r.page_number;
            held_app[free_at] = r.app_id;
            res.slot = swt_pkg::SLOT_W'(free_at);
            res.accepted = 1'b1;
            outs_tally++;
         end else begin
            swap_fails++;
         end
      end else if (hit_at >= 0) begin
         res.slot = swt_pkg::SLOT_W'(hit_at);
      end
      res.swap_in_count = ins_tally;
      res.swap_out_count = outs_tally;
      res.failed_count = swap_fails;
      return res;
   endfunction

   function automatic swt_pkg::req_type key_request(logic [swt_pkg::KIND_W-1:0] kind,
                                                    int k);
      swt_pkg::req_type r;
      r.kind = kind;
      r.page_number = key_page[k];
      r.app_id = key_app[k];
      return r;
   endfunction

   function automatic swt_pkg::req_type random_request();
      swt_pkg::req_type r;
      int      roll;
      int      bit_pos;
      roll = $urandom_range(99);
      r = key_request(swt_pkg::KIND_LOOKUP, $urandom_range(KEYS - 1));
      if (roll < 25) begin
         r.kind = swt_pkg::KIND_LOOKUP;
      end else if (roll < 55) begin
         r.kind = swt_pkg::KIND_SWAP_IN;
      end else if (roll < 95) begin
         r.kind = swt_pkg::KIND_SWAP_OUT;
      end else begin
         r.kind = KIND_UNUSED;
      end
      // near-miss keys: one bit off a known key
      if (r.kind != swt_pkg::KIND_SWAP_OUT && $urandom_range(99) < 20) begin
         bit_pos = $urandom_range(swt_pkg::PAGE_W + swt_pkg::APP_W - 1);
         if (bit_pos < swt_pkg::PAGE_W) begin
            r.page_number[bit_pos] = ~r.page_number[bit_pos];
         end else begin
            r.app_id[bit_pos - swt_pkg::PAGE_W] = ~r.app_id[bit_pos - swt_pkg::PAGE_W];
         end
      end
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      swt_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            compare_field("found", want.found, rsp_data.found);
            compare_field("accepted", want.accepted, rsp_data.accepted);
            compare_field("slot", want.slot, rsp_data.slot);
            compare_field("swap_in_count", want.swap_in_count, rsp_data.swap_in_count);
            compare_field("swap_out_count", want.swap_out_count, rsp_data.swap_out_count);
            compare_field("failed_count", want.failed_count, rsp_data.failed_count);
         end
      end
   end

   task automatic send_request(swt_pkg::req_type r);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_rsp.push_back(apply_request(r));
      sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
   endtask

   task automatic write_limit(logic [swt_pkg::LIMIT_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      limit_setting = value;
      limit_writes++;
   endtask

   task automatic run_random_traffic(logic [swt_pkg::LIMIT_W-1:0] value, int idle_pct,
                                     int stall_pct, int count);
      write_limit(value);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) send_request(random_request());
   endtask

   task automatic test_basic_operations();
      send_request(key_request(swt_pkg::KIND_LOOKUP, 0));
      send_request(key_request(swt_pkg::KIND_SWAP_IN, 0));
      send_request(key_request(swt_pkg::KIND_SWAP_OUT, 0));
      send_request(key_request(swt_pkg::KIND_SWAP_OUT, 1));
      send_request(key_request(swt_pkg::KIND_LOOKUP, 0));
      send_request(key_request(swt_pkg::KIND_LOOKUP, 1));
      send_request(key_request(KIND_UNUSED, 1));
      send_request(key_request(swt_pkg::KIND_SWAP_OUT, 0));
      send_request(key_request(swt_pkg::KIND_SWAP_OUT, 2));
      send_request(key_request(swt_pkg::KIND_SWAP_IN, 1));
      send_request(key_request(swt_pkg::KIND_SWAP_IN, 1));
   endtask

   task automatic test_limit_corners();
      write_limit(swt_pkg::LIMIT_W'(2));
      send_request(key_request(swt_pkg::KIND_SWAP_OUT, 3));
      send_request(key_request(swt_pkg::KIND_SWAP_OUT, 4));
      send_request(key_request(swt_pkg::KIND_SWAP_OUT, 0));
      send_request(key_request(swt_pkg::KIND_LOOKUP, 0));
      send_request(key_request(swt_pkg::KIND_SWAP_IN, 0));
      send_request(key_request(swt_pkg::KIND_LOOKUP, 0));
      write_limit('0);
      send_request(key_request(swt_pkg::KIND_SWAP_OUT, 4));
      send_request(key_request(swt_pkg::KIND_SWAP_OUT, 2));
      send_request(key_request(swt_pkg::KIND_LOOKUP, 2));
      write_limit('1);
      send_request(key_request(swt_pkg::KIND_SWAP_OUT, 4));
      write_limit(swt_pkg::LIMIT_W'(1));
      send_request(key_request(swt_pkg::KIND_SWAP_OUT, 5));
   endtask

   task automatic test_full_rate();
      run_random_traffic(swt_pkg::LIMIT_W'(SLOTS), 0, 0, 100);
      run_random_traffic('0, 0, 0, 30);
   endtask

   task automatic test_sender_gaps();
      run_random_traffic(swt_pkg::LIMIT_W'(3), 86, 0, 90);
   endtask

   task automatic test_receiver_stalls();
      run_random_traffic(swt_pkg::LIMIT_W'(1), 0, 86, 70);
      run_random_traffic(swt_pkg::LIMIT_W'(SLOTS - 1), 0, 86, 60);
   endtask

   task automatic test_mixed_idling();
      run_random_traffic(swt_pkg::LIMIT_W'(12), 9, 9, 110);
      run_random_traffic('1, 9, 9, 100);
   endtask

   initial begin
      foreach (key_page[k]) begin
         key_page[k] = swt_pkg::PAGE_W'({$urandom, $urandom});
         key_app[k] = swt_pkg::APP_W'($urandom);
      end
      key_page[0] = '0;
      key_app[0] = '0;
      key_page[1] = '1;
      key_app[1] = '1;
      key_page[3] = key_page[2];
      key_app[3] = ~key_app[2];
      key_page[5] = key_page[4] ^ swt_pkg::PAGE_W'(1);
      key_app[5] = key_app[4];

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_basic_operations();
      test_limit_corners();
      test_full_rate();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();

      wait_idle();
      repeat (SETTLE) @(posedge clock);
      $display("%0d requests over %0d slot limit settings, with and without idle and stall",
               sent, limit_writes);
      $display("swap-ins %0d, swap-outs placed %0d, swap-outs refused %0d",
               ins_tally, outs_tally, swap_fails);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
